>>> rtl/core/hashed_name_set_engine_macros.svh
// assertion macros for the hashed name set engine
// used by hnse_ctrl and hnse_dp; expects clk and rst_n in scope
`ifndef HASHED_NAME_SET_ENGINE_MACROS_SVH
`define HASHED_NAME_SET_ENGINE_MACROS_SVH

// same-cycle implication
`define HNSE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HNSE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/hnse_pkg.sv
// shared types, codes and hash functions for the hashed name set engine
// no dependencies
package hnse_pkg;

    localparam int NAME_BYTES      = 16;
    localparam int KEY_BITS        = NAME_BYTES * 8;
    localparam int BUCKET_BITS_DEF = 10;
    localparam int WAYS_DEF        = 4;
    localparam int HASH_STEPS      = 13;
    localparam int STEP_W          = 4;
    localparam logic [31:0] JH_INIT = 32'hdeadbeef + 32'd16;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_DEL   = 2'd1;
    localparam logic [1:0] KIND_TEST  = 2'd2;
    localparam logic [1:0] KIND_FLUSH = 2'd3;

    localparam logic [2:0] ST_DONE        = 3'd0;
    localparam logic [2:0] ST_PRESENT     = 3'd1;
    localparam logic [2:0] ST_ABSENT      = 3'd2;
    localparam logic [2:0] ST_ALREADY     = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd4;
    localparam logic [2:0] ST_BAD_NAME    = 3'd5;
    localparam logic [2:0] ST_BUCKET_FULL = 3'd6;

    typedef struct packed {
        logic load;
        logic hash_step;
        logic v_rd;
        logic k_rd;
        logic k_cmp;
        logic clr_wr;
        logic commit;
    } hnse_cmd_t;

    typedef struct packed {
        logic is_flush;
        logic early;
        logic out_free;
    } hnse_sts_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } hnse_abc_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

    // one line of the lookup3 mix / final rounds
    function automatic hnse_abc_t jh_step(input logic [STEP_W-1:0] step,
                                          input hnse_abc_t s,
                                          input logic [31:0] k3);
        hnse_abc_t r;
        r = s;
        case (step)
            4'd0:  begin r.a = (s.a - s.c) ^ rotl(s.c, 4);  r.c = s.c + s.b; end
            4'd1:  begin r.b = (s.b - s.a) ^ rotl(s.a, 6);  r.a = s.a + s.c; end
            4'd2:  begin r.c = (s.c - s.b) ^ rotl(s.b, 8);  r.b = s.b + s.a; end
            4'd3:  begin r.a = (s.a - s.c) ^ rotl(s.c, 16); r.c = s.c + s.b; end
            4'd4:  begin r.b = (s.b - s.a) ^ rotl(s.a, 19); r.a = s.a + s.c; end
            4'd5:  begin r.c = (s.c - s.b) ^ rotl(s.b, 4);  r.b = s.b + s.a; end
            4'd6:  begin r.a = s.a + k3; r.c = (s.c ^ s.b) - rotl(s.b, 14); end
            4'd7:  r.a = (s.a ^ s.c) - rotl(s.c, 11);
            4'd8:  r.b = (s.b ^ s.a) - rotl(s.a, 25);
            4'd9:  r.c = (s.c ^ s.b) - rotl(s.b, 16);
            4'd10: r.a = (s.a ^ s.c) - rotl(s.c, 4);
            4'd11: r.b = (s.b ^ s.a) - rotl(s.a, 14);
            4'd12: r.c = (s.c ^ s.b) - rotl(s.b, 24);
            default: r = s;
        endcase
        jh_step = r;
    endfunction

    // first byte nonzero and a terminator somewhere after it
    function automatic logic name_ok(input logic [KEY_BITS-1:0] k);
        logic z;
        z = 1'b0;
        for (int i = 1; i < NAME_BYTES; i++) begin
            z = z | (k[i*8 +: 8] == 8'd0);
        end
        name_ok = (k[7:0] != 8'd0) && z;
    endfunction

    // equal up to and including the terminator of x
    function automatic logic names_equal(input logic [KEY_BITS-1:0] x,
                                         input logic [KEY_BITS-1:0] y);
        logic seen;
        logic ok;
        seen = 1'b0;
        ok   = 1'b1;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (!seen && (x[i*8 +: 8] != y[i*8 +: 8])) begin
                ok = 1'b0;
            end
            seen = seen | (x[i*8 +: 8] == 8'd0);
        end
        names_equal = ok;
    endfunction

endpackage

>>> rtl/core/hnse_ctrl.sv
// controller state machine of the hashed name set engine
// depends on hnse_pkg and hashed_name_set_engine_macros.svh
`include "hashed_name_set_engine_macros.svh"

module hnse_ctrl #(
    parameter int BUCKET_BITS = hnse_pkg::BUCKET_BITS_DEF,
    parameter int WAYS        = hnse_pkg::WAYS_DEF,
    parameter int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  hnse_pkg::hnse_sts_t        sts,
    output hnse_pkg::hnse_cmd_t        cmd,
    output logic [hnse_pkg::STEP_W-1:0] step,
    output logic [WAY_W-1:0]           way_idx,
    output logic [BUCKET_BITS-1:0]     clr_addr
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_HASH   = 3'd3;
    localparam logic [2:0] S_VREAD  = 3'd4;
    localparam logic [2:0] S_KREAD  = 3'd5;
    localparam logic [2:0] S_KCMP   = 3'd6;
    localparam logic [2:0] S_COMMIT = 3'd7;

    localparam logic [BUCKET_BITS-1:0] CLR_LAST = '1;
    localparam logic [WAY_W-1:0]       WAY_LAST = WAY_W'(WAYS - 1);
    localparam logic [hnse_pkg::STEP_W-1:0] STEP_LAST =
        hnse_pkg::STEP_W'(hnse_pkg::HASH_STEPS - 1);

    logic [2:0]                  state_reg, state_next;
    logic [BUCKET_BITS-1:0]      clr_reg, clr_next;
    logic [hnse_pkg::STEP_W-1:0] step_reg, step_next;
    logic [WAY_W-1:0]            way_reg, way_next;
    logic                        flush_reg, flush_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            step_reg  <= '0;
            way_reg   <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            step_reg  <= step_next;
            way_reg   <= way_next;
            flush_reg <= flush_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        step_next  = step_reg;
        way_next   = way_reg;
        flush_next = flush_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = flush_reg ? S_COMMIT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                step_next = '0;
                clr_next  = '0;
                if (sts.is_flush)
                begin
                    flush_next = 1'b1;
                    state_next = S_CLEAR;
                end
                else if (sts.early)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_VREAD;
                end
            end
            S_VREAD:
            begin
                cmd.v_rd   = 1'b1;
                way_next   = '0;
                state_next = S_KREAD;
            end
            S_KREAD:
            begin
                cmd.k_rd   = 1'b1;
                state_next = S_KCMP;
            end
            S_KCMP:
            begin
                cmd.k_cmp = 1'b1;
                if (way_reg == WAY_LAST)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    way_next   = way_reg + 1'b1;
                    state_next = S_KREAD;
                end
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    flush_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign step     = step_reg;
    assign way_idx  = way_reg;
    assign clr_addr = clr_reg;

    `HNSE_ASSERT_IMP(a_commit_slot, cmd.commit, sts.out_free, "commit without a free result slot")
    `HNSE_ASSERT_NXT(a_load_check, cmd.load, state_reg == S_CHECK, "load not followed by check")
    `HNSE_ASSERT_IMP(a_no_overlap, cmd.clr_wr, !in_ready && !cmd.commit, "clear overlaps work")

endmodule

>>> rtl/core/hnse_dp.sv
// datapath of the hashed name set engine: hash unit, tables, result register
// depends on hnse_pkg and hashed_name_set_engine_macros.svh
`include "hashed_name_set_engine_macros.svh"

module hnse_dp #(
    parameter int BUCKET_BITS = hnse_pkg::BUCKET_BITS_DEF,
    parameter int WAYS        = hnse_pkg::WAYS_DEF,
    parameter int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1,
    parameter int CNT_W       = BUCKET_BITS + $clog2(WAYS) + 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [31:0]                  cfg_data,
    input  logic [1:0]                   in_kind,
    input  logic [hnse_pkg::KEY_BITS-1:0] in_key,
    input  hnse_pkg::hnse_cmd_t          cmd,
    input  logic [hnse_pkg::STEP_W-1:0]  step,
    input  logic [WAY_W-1:0]             way_idx,
    input  logic [BUCKET_BITS-1:0]       clr_addr,
    output hnse_pkg::hnse_sts_t          sts,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   out_status,
    output logic [CNT_W-1:0]             out_count,
    output logic [BUCKET_BITS-1:0]       out_bucket
);

    localparam int NBUCKETS = 1 << BUCKET_BITS;
    localparam int NENTRY   = NBUCKETS * WAYS;
    localparam int KA_W     = $clog2(NENTRY);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NENTRY);

    logic [31:0]                   seed_reg;
    logic [1:0]                    kind_reg;
    logic [hnse_pkg::KEY_BITS-1:0] key_reg;
    hnse_pkg::hnse_abc_t           abc_reg, abc_next;
    logic                          found_reg;
    logic [WAY_W-1:0]              fway_reg;
    logic [CNT_W-1:0]              count_reg;
    logic                          out_valid_reg;
    logic [2:0]                    out_status_reg;
    logic [CNT_W-1:0]              out_count_reg;
    logic [BUCKET_BITS-1:0]        out_bucket_reg;

    logic [WAYS-1:0]               valid_mem [NBUCKETS];
    logic [hnse_pkg::KEY_BITS-1:0] key_mem [NENTRY];
    logic [WAYS-1:0]               vrd_q;
    logic [hnse_pkg::KEY_BITS-1:0] krd_q;

    logic [BUCKET_BITS-1:0] bucket;
    logic                   early;
    logic                   free_any;
    logic [WAY_W-1:0]       free_way;
    logic [2:0]             res_status;
    logic [CNT_W-1:0]       res_count;
    logic [BUCKET_BITS-1:0] res_bucket;
    logic                   v_we, k_we;
    logic [WAYS-1:0]        v_wdata;
    logic [KA_W-1:0]        k_rd_addr, k_wr_addr;

    assign bucket = abc_reg.c[BUCKET_BITS-1:0];
    assign early  = ((kind_reg == hnse_pkg::KIND_ADD) && (count_reg >= CNT_MAX))
                    || !hnse_pkg::name_ok(key_reg);

    assign sts.is_flush = (kind_reg == hnse_pkg::KIND_FLUSH);
    assign sts.early    = early;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign k_rd_addr = KA_W'(bucket) * KA_W'(WAYS) + KA_W'(way_idx);
    assign k_wr_addr = KA_W'(bucket) * KA_W'(WAYS) + KA_W'(free_way);

    // lowest free way
    always_comb
    begin
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!vrd_q[w])
            begin
                free_way = WAY_W'(w);
            end
        end
        free_any = !(&vrd_q);
    end

    always_comb
    begin
        abc_next = hnse_pkg::jh_step(step, abc_reg, key_reg[127:96]);
    end

    // decision on commit
    always_comb
    begin
        res_status = hnse_pkg::ST_DONE;
        res_count  = count_reg;
        res_bucket = '0;
        v_we       = 1'b0;
        k_we       = 1'b0;
        v_wdata    = vrd_q;
        if (kind_reg == hnse_pkg::KIND_FLUSH)
        begin
            res_count = '0;
        end
        else if ((kind_reg == hnse_pkg::KIND_ADD) && (count_reg >= CNT_MAX))
        begin
            res_status = hnse_pkg::ST_TABLE_FULL;
        end
        else if (!hnse_pkg::name_ok(key_reg))
        begin
            res_status = hnse_pkg::ST_BAD_NAME;
        end
        else
        begin
            res_bucket = bucket;
            case (kind_reg)
                hnse_pkg::KIND_ADD:
                begin
                    if (found_reg)
                    begin
                        res_status = hnse_pkg::ST_ALREADY;
                    end
                    else if (!free_any)
                    begin
                        res_status = hnse_pkg::ST_BUCKET_FULL;
                    end
                    else
                    begin
                        v_we              = 1'b1;
                        k_we              = 1'b1;
                        v_wdata[free_way] = 1'b1;
                        res_count         = count_reg + 1'b1;
                    end
                end
                hnse_pkg::KIND_DEL:
                begin
                    if (found_reg)
                    begin
                        v_we              = 1'b1;
                        v_wdata[fway_reg] = 1'b0;
                        if (count_reg != '0)
                        begin
                            res_count = count_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        res_status = hnse_pkg::ST_ABSENT;
                    end
                end
                default:
                begin
                    res_status = found_reg ? hnse_pkg::ST_PRESENT : hnse_pkg::ST_ABSENT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                seed_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                count_reg     <= res_count;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= in_kind;
            key_reg   <= in_key;
            abc_reg.a <= hnse_pkg::JH_INIT + seed_reg + in_key[31:0];
            abc_reg.b <= hnse_pkg::JH_INIT + seed_reg + in_key[63:32];
            abc_reg.c <= hnse_pkg::JH_INIT + seed_reg + in_key[95:64];
            found_reg <= 1'b0;
            fway_reg  <= '0;
        end
        else if (cmd.hash_step)
        begin
            abc_reg <= abc_next;
        end
        if (cmd.k_cmp && vrd_q[way_idx] && hnse_pkg::names_equal(krd_q, key_reg))
        begin
            found_reg <= 1'b1;
            fway_reg  <= way_idx;
        end
        if (cmd.commit)
        begin
            out_status_reg <= res_status;
            out_count_reg  <= res_count;
            out_bucket_reg <= res_bucket;
        end
    end

    // bucket valid masks
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            valid_mem[clr_addr] <= '0;
        end
        else if (cmd.commit && v_we)
        begin
            valid_mem[bucket] <= v_wdata;
        end
        if (cmd.v_rd)
        begin
            vrd_q <= valid_mem[bucket];
        end
    end

    // stored names
    always_ff @(posedge clk)
    begin
        if (cmd.commit && k_we)
        begin
            key_mem[k_wr_addr] <= key_reg;
        end
        if (cmd.k_rd)
        begin
            krd_q <= key_mem[k_rd_addr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;
    assign out_bucket = out_bucket_reg;

    `HNSE_ASSERT_IMP(a_count_max, 1'b1, count_reg <= CNT_MAX, "element count above capacity")
    `HNSE_ASSERT_NXT(a_commit_out, cmd.commit, out_valid_reg, "commit did not present a result")
    `HNSE_ASSERT_NXT(a_flush_zero, cmd.commit && sts.is_flush, count_reg == '0, "flush left entries")

endmodule

>>> rtl/core/hashed_name_set_engine.sv
// hashed name set engine: add/delete/test run the hash (13 hash steps), one mask read and a key
// read and compare per way (W ways); bad name or table full skip to the result, and flush
// sweeps all valid masks; handles one transaction at a time, set by the shared hash round unit
// and the single key memory port scanning ways in turn
// after reset all 2^BUCKET_BITS valid masks (1024 by default) are swept with
// s_tready low; the configuration channel is always ready
module hashed_name_set_engine #(
    parameter int BUCKET_BITS = hnse_pkg::BUCKET_BITS_DEF,
    parameter int WAYS        = hnse_pkg::WAYS_DEF,
    parameter int CNT_W       = BUCKET_BITS + $clog2(WAYS) + 1,
    parameter int OUT_W       = ((CNT_W + BUCKET_BITS + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration: hash seed
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [31:0]                    cfg_data,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hnse_pkg::KEY_BITS-1:0]  s_tdata,   // key_word0..key_word3
    input  logic [7:0]                     s_tuser,   // kind, zero pad
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [OUT_W-1:0]               m_tdata,   // element_count, bucket_index, zero pad
    output logic [7:0]                     m_tuser    // status, zero pad
);

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    hnse_pkg::hnse_cmd_t         cmd;
    hnse_pkg::hnse_sts_t         sts;
    logic [hnse_pkg::STEP_W-1:0] step;
    logic [WAY_W-1:0]            way_idx;
    logic [BUCKET_BITS-1:0]      clr_addr;
    logic [2:0]                  out_status;
    logic [CNT_W-1:0]            out_count;
    logic [BUCKET_BITS-1:0]      out_bucket;

    // seed register is written whenever offered
    assign cfg_ready = 1'b1;

    hnse_ctrl #(
        .BUCKET_BITS (BUCKET_BITS),
        .WAYS        (WAYS),
        .WAY_W       (WAY_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd),
        .step     (step),
        .way_idx  (way_idx),
        .clr_addr (clr_addr)
    );

    hnse_dp #(
        .BUCKET_BITS (BUCKET_BITS),
        .WAYS        (WAYS),
        .WAY_W       (WAY_W),
        .CNT_W       (CNT_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_kind    (s_tuser[1:0]),
        .in_key     (s_tdata),
        .cmd        (cmd),
        .step       (step),
        .way_idx    (way_idx),
        .clr_addr   (clr_addr),
        .sts        (sts),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_count  (out_count),
        .out_bucket (out_bucket)
    );

    // pack result fields, lowest first
    assign m_tdata = OUT_W'({out_bucket, out_count});
    assign m_tuser = {5'd0, out_status};

endmodule
